>>> hdl/dipc_pkg.sv
// Shared types, character codes and range checks for the dotted IPv4 classifier.
package dipc_pkg;

    localparam int CharWidth = 16;
    localparam int OctetWidth = 8;
    localparam int OutBytes = 8;

    localparam logic [CharWidth-1:0] CharZero = 16'h0030;
    localparam logic [CharWidth-1:0] CharNine = 16'h0039;
    localparam logic [CharWidth-1:0] CharDot  = 16'h002E;

    localparam logic [1:0] LastDotIndex = 2'd3;
    localparam logic [11:0] OctetMax = 12'd255;

    // Parse progress for the text being received.
    typedef struct packed {
        logic [1:0]            octet_count;
        logic [OctetWidth-1:0] octet_value;
        logic                  digit_seen;
        logic [OctetWidth-1:0] first_octet;
        logic [OctetWidth-1:0] second_octet;
        logic                  parse_failed;
    } parse_state_t;

    // True for 10/8, 127/8, 172.16/12, 192.168/16 and 169.254/16.
    function automatic logic in_private_range(input logic [OctetWidth-1:0] a,
                                              input logic [OctetWidth-1:0] b);
        logic hit;
        hit = (a == 8'd10)
            || (a == 8'd127)
            || ((a == 8'd172) && (b >= 8'd16) && (b <= 8'd31))
            || ((a == 8'd192) && (b == 8'd168))
            || ((a == 8'd169) && (b == 8'd254));
        return hit;
    endfunction

endpackage

>>> hdl/dipc_parse.sv
// Per-character update of the dotted-quad parse state.
module dipc_parse (
    input  dipc_pkg::parse_state_t           cur,
    input  logic [dipc_pkg::CharWidth-1:0]   character,
    output dipc_pkg::parse_state_t           nxt
);
    import dipc_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] times_ten;

    assign is_digit = (character >= CharZero) && (character <= CharNine);
    assign digit = 4'(character - CharZero);
    // value * 10 + digit, built from shifts so no multiplier is needed.
    assign times_ten = ({4'd0, cur.octet_value} << 3) + ({4'd0, cur.octet_value} << 1)
                     + {8'd0, digit};

    always_comb
    begin
        nxt = cur;
        priority if (cur.parse_failed)
        begin
            nxt = cur;
        end
        else if (character == CharDot)
        begin
            if (!cur.digit_seen || (cur.octet_count == LastDotIndex))
            begin
                nxt.parse_failed = 1'b1;
            end
            else
            begin
                if (cur.octet_count == 2'd0)
                    nxt.first_octet = cur.octet_value;
                else if (cur.octet_count == 2'd1)
                    nxt.second_octet = cur.octet_value;
                nxt.octet_count = cur.octet_count + 2'd1;
                nxt.octet_value = '0;
                nxt.digit_seen = 1'b0;
            end
        end
        else if (!is_digit)
        begin
            nxt.parse_failed = 1'b1;
        end
        else if (times_ten > OctetMax)
        begin
            nxt.parse_failed = 1'b1;
        end
        else
        begin
            nxt.octet_value = times_ten[OctetWidth-1:0];
            nxt.digit_seen = 1'b1;
        end
    end

endmodule

>>> hdl/dotted_ipv4_private_classifier.sv
// Top level of the dotted IPv4 private-range classifier.
//
//  Channel   Direction  Handshake                   Content
//  s_axis    in         s_axis_tvalid/tready        one character, or tlast closing the text
//  m_axis    out        m_axis_tvalid/tready        one result per closed text
//
// Each request passes an input register, then the parse logic, which updates the
// parse state and, for a closing request, loads the result register.
// One request is accepted per cycle while no closing request stalls; the result is
// offered on m_axis_tvalid once its closing request has passed the input register
// and loaded the result register. Characters never wait on the output side; only
// a closing request stalls while the result register still holds an untaken result.
// Reset (rst_n low, asynchronous) clears the parse state and both valid flags.
// Between texts the parse state returns to all zeros.
module dotted_ipv4_private_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] character
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] is_private, [1] well_formed, [7:2] zero
);
    import dipc_pkg::*;

    // Input register.
    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_last_reg;

    // Parse state and result register.
    parse_state_t         parse_reg;
    parse_state_t         parse_next;
    parse_state_t         step_state;
    logic                 out_valid_reg;
    logic                 out_private_reg;
    logic                 out_well_formed_reg;
    logic                 out_private_next;
    logic                 out_well_formed_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 proc_go;
    logic                 proc_close;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    // A character always moves on; a closing request needs room for its result.
    assign proc_go = in_valid_reg && (!in_last_reg || out_free);
    assign proc_close = proc_go && in_last_reg;
    assign s_axis_tready = !in_valid_reg || proc_go;

    dipc_parse u_parse (
        .cur       (parse_reg),
        .character (in_char_reg),
        .nxt       (step_state)
    );

    always_comb
    begin
        out_well_formed_next = !parse_reg.parse_failed && parse_reg.digit_seen
                             && (parse_reg.octet_count == LastDotIndex);
        out_private_next = out_well_formed_next
                         && in_private_range(parse_reg.first_octet, parse_reg.second_octet);
        parse_next = parse_reg;
        if (proc_go)
        begin
            if (in_last_reg)
                parse_next = '0;
            else
                parse_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            parse_reg <= parse_next;
            if (proc_close)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_close)
        begin
            out_private_reg <= out_private_next;
            out_well_formed_reg <= out_well_formed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(OutBytes-2){1'b0}}, out_well_formed_reg, out_private_reg};

    // A closed text always leaves the parse state cleared.
    a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        proc_close |=> (parse_reg == '0))
        else $error("parse state not cleared after closing request");

    // The fail mark stays set until the text closes.
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_reg.parse_failed && !proc_close) |=> parse_reg.parse_failed)
        else $error("fail mark dropped before the text closed");

    // A result only appears after a closing request was processed.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_close))
        else $error("result appeared without a closing request");

    // Only well-formed text may be classified as private.
    a_private_needs_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_private_reg || out_well_formed_reg))
        else $error("private result on malformed text");

endmodule

>>> bench/dipc_checker.sv
// Checker for the dotted IPv4 classifier: predicts each text verdict and compares the results.
`timescale 1ns / 1ps

module dipc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          mismatch_count,
    output int          results_owed
);
    import dipc_pkg::*;

    localparam logic [OctetWidth-1:0] NetTen          = 8'd10;
    localparam logic [OctetWidth-1:0] NetLoopback     = 8'd127;
    localparam logic [OctetWidth-1:0] NetClassB       = 8'd172;
    localparam logic [OctetWidth-1:0] ClassBLow       = 8'd16;
    localparam logic [OctetWidth-1:0] ClassBHigh      = 8'd31;
    localparam logic [OctetWidth-1:0] NetClassC       = 8'd192;
    localparam logic [OctetWidth-1:0] ClassCSecond    = 8'd168;
    localparam logic [OctetWidth-1:0] NetLinkLocal    = 8'd169;
    localparam logic [OctetWidth-1:0] LinkLocalSecond = 8'd254;

    // Packed so that is_private lands in bit 0 and well_formed in bit 1.
    typedef struct packed {
        logic well_formed;
        logic is_private;
    } text_verdict_t;

    parse_state_t  parse_now;
    text_verdict_t verdicts_due[$];

    // Advances the parse by one character. Once the fail mark is set the text is ignored.
    function automatic parse_state_t take_character(parse_state_t st, logic [CharWidth-1:0] ch);
        parse_state_t nx;
        logic [11:0]  grown;
        nx = st;
        if (!st.parse_failed) begin
            if (ch == CharDot) begin
                if (!st.digit_seen || st.octet_count == LastDotIndex) begin
                    nx.parse_failed = 1'b1;
                end
                else begin
                    if (st.octet_count == 2'd0) begin
                        nx.first_octet = st.octet_value;
                    end
                    else if (st.octet_count == 2'd1) begin
                        nx.second_octet = st.octet_value;
                    end
                    nx.octet_count = st.octet_count + 2'd1;
                    nx.octet_value = '0;
                    nx.digit_seen  = 1'b0;
                end
            end
            else if (ch < CharZero || ch > CharNine) begin
                nx.parse_failed = 1'b1;
            end
            else begin
                grown = 12'(st.octet_value) * 12'd10 + 12'(ch - CharZero);
                if (grown > OctetMax) begin
                    nx.parse_failed = 1'b1;
                end
                else begin
                    nx.octet_value = grown[OctetWidth-1:0];
                    nx.digit_seen  = 1'b1;
                end
            end
        end
        return nx;
    endfunction

    function automatic logic lies_in_local_block(logic [OctetWidth-1:0] a,
                                                 logic [OctetWidth-1:0] b);
        return (a == NetTen) || (a == NetLoopback)
            || (a == NetClassB && b >= ClassBLow && b <= ClassBHigh)
            || (a == NetClassC && b == ClassCSecond)
            || (a == NetLinkLocal && b == LinkLocalSecond);
    endfunction

    function automatic text_verdict_t close_text(parse_state_t st);
        text_verdict_t v;
        v.well_formed = !st.parse_failed && st.digit_seen && (st.octet_count == LastDotIndex);
        v.is_private  = v.well_formed && lies_in_local_block(st.first_octet, st.second_octet);
        return v;
    endfunction

    task automatic compare_field(string field, logic [5:0] want, logic [5:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        text_verdict_t want;
        if (!rst_n) begin
            parse_now = '0;
            verdicts_due.delete();
            mismatch_count = 0;
            results_owed = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end
                else begin
                    want = verdicts_due.pop_front();
                    compare_field("is_private", 6'(want.is_private), 6'(m_axis_tdata[0]));
                    compare_field("well_formed", 6'(want.well_formed), 6'(m_axis_tdata[1]));
                    compare_field("padding", 6'd0, m_axis_tdata[7:2]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tlast) begin
                    verdicts_due.push_back(close_text(parse_now));
                    parse_now = '0;
                end
                else begin
                    parse_now = take_character(parse_now, s_axis_tdata);
                end
            end
            results_owed = verdicts_due.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Top of the testbench: clock, reset, host-text stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_top;
    import dipc_pkg::*;

    // Random requests per idling phase; with the directed texts, about 1850 in all.
    localparam int PhaseRequests  = 395;
    // Length of the one long receiver hold-off, in clock cycles.
    localparam int LongHoldCycles = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] character
    logic        s_axis_tlast = 1'b0;   // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [0] is_private, [1] well_formed, [7:2] zero

    int mismatch_count;
    int results_owed;

    // Idling is set per phase by the stimulus process and read by both sides.
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    // Each increment asks the result sink for one long hold-off.
    int hold_requests     = 0;
    int requests_sent     = 0;

    // Characters of the text being built, in send order.
    logic [15:0] text_chars[$];

    int sender_idle_by_phase[4]   = '{0, 46, 0, 13};
    int receiver_stall_by_phase[4] = '{0, 0, 46, 13};

    // Directed texts: every private range, with near misses for the 172, 192 and 169 ones,
    // the address extremes, and each way the dotted form can break.
    string directed_texts[23] = '{
        "", "10.0.0.1", "127.1.1.1", "172.16.0.0", "172.31.9.9", "172.15.0.1",
        "172.32.0.1", "192.168.0.1", "192.169.0.1", "169.254.1.1", "169.253.1.1",
        "255.255.255.255", "0.0.0.0", "256.1.1.1", "1.2.3", "1.2.3.4.5", "1..2.3",
        ".1.2.3", "1.2.3.", "010.0.0.1", "1a.2.3.4", "1/.2.3.4", "1:.2.3.4"
    };

    always #2 clk = ~clk;

    dotted_ipv4_private_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dipc_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Offers one request and returns at the falling edge after it was taken. It is
    // entered at a falling edge, and tvalid stays high between back-to-back requests
    // so that it is never lowered and raised in the same time step.
    task automatic send_request(logic [15:0] data, logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        @(negedge clk);
    endtask

    // Sends the built text and then the closing request, whose character is don't-care
    // and so gets random bits.
    task automatic send_text_chars();
        foreach (text_chars[i]) begin
            send_request(text_chars[i], 1'b0);
        end
        send_request(16'($urandom_range(0, 65535)), 1'b1);
    endtask

    task automatic append_string(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_chars.push_back({8'h00, s[i]});
        end
    endtask

    task automatic send_string(string s);
        text_chars.delete();
        append_string(s);
        send_text_chars();
    endtask

    // Stops offering requests until every expected result has come back. It always
    // waits for a falling edge before it checks, so the next request never lands in this time step.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (results_owed != 0);
    endtask

    // An octet in decimal, now and then with a leading zero that must not change it.
    function automatic string octet_text(int v);
        string txt;
        txt = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0) begin
            txt = {"0", txt};
        end
        return txt;
    endfunction

    // A character that is full 16-bit noise, a 7-bit code, a dot, a digit, or
    // one of the codes just outside the digit range.
    function automatic logic [15:0] pick_noise_char();
        logic [15:0] ch;
        case ($urandom_range(0, 4))
            0: ch = 16'($urandom_range(0, 65535));
            1: ch = CharDot;
            2: ch = CharZero + 16'($urandom_range(0, 9));
            3: ch = ($urandom_range(0, 1) != 0) ? CharZero - 16'd1 : CharNine + 16'd1;
            default: ch = 16'($urandom_range(0, 127));
        endcase
        return ch;
    endfunction

    // Builds one random text. Most are dotted quads biased toward the private ranges
    // and their edges; roughly 30 percent of those are then altered in one spot. The
    // rest are empty texts or plain noise.
    task automatic build_random_text();
        int kind;
        int pos;
        int a;
        int b;
        kind = $urandom_range(0, 99);
        text_chars.delete();
        if (kind < 4) begin
            return;
        end
        if (kind < 14) begin
            repeat ($urandom_range(1, 6)) text_chars.push_back(pick_noise_char());
            return;
        end
        case ($urandom_range(0, 5))
            0: a = 10;
            1: a = 127;
            2: a = 172;
            3: a = 192;
            4: a = 169;
            default: a = $urandom_range(0, 255);
        endcase
        case (a)
            172: b = $urandom_range(14, 33);
            192: b = $urandom_range(167, 169);
            169: b = $urandom_range(253, 255);
            default: b = $urandom_range(0, 255);
        endcase
        append_string({octet_text(a), ".", octet_text(b), ".",
                       octet_text($urandom_range(0, 255)), ".",
                       octet_text($urandom_range(0, 255))});
        if (kind < 74) begin
            return;
        end
        pos = $urandom_range(0, text_chars.size());
        case ($urandom_range(0, 5))
            0: text_chars.insert(pos, pick_noise_char());
            1: text_chars.insert(pos, CharDot);
            2: text_chars.delete(pos % text_chars.size());
            3: append_string({".", octet_text($urandom_range(0, 255))});
            // An extra digit may push an octet past 255, or merely lengthen it.
            4: text_chars.insert(pos, CharZero + 16'($urandom_range(0, 9)));
            default: text_chars = text_chars[0:pos-1];
        endcase
    endtask

    // Result sink. It stalls at the phase's rate, and serves a long hold-off whenever
    // the stimulus asks for one, counting it down here cycle by cycle.
    initial begin : result_sink
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = LongHoldCycles;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else begin
                m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    initial begin : stimulus
        int target;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_texts[i]) begin
            send_string(directed_texts[i]);
        end
        // Wide characters: all high bits set, and codes whose low byte alone would
        // read as a digit or a dot. Each one must break the text.
        text_chars.delete();
        append_string("1.2.3.4");
        text_chars.insert(1, 16'hFFFF);
        send_text_chars();
        text_chars.delete();
        append_string("10.2.3.4");
        text_chars.insert(2, 16'h0130);
        send_text_chars();
        text_chars.delete();
        append_string("192168.1.1");
        text_chars.insert(3, 16'h012E);
        send_text_chars();
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct = sender_idle_by_phase[phase];
            receiver_stall_pct = receiver_stall_by_phase[phase];
            // In the phase without idling, hold results back for a long stretch so
            // that the result register fills and closing requests stall the input.
            if (phase == 0) begin
                hold_requests++;
            end
            target = requests_sent + PhaseRequests;
            while (requests_sent < target) begin
                build_random_text();
                send_text_chars();
            end
            // Pause until every expected result has come back.
            drain_results();
        end

        // Wait on after the drain to catch any stray result.
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
